// ===== rtl/core/wlp_pkg.sv =====
// Shared types and constants for the windowed load percentage unit.
package wlp_pkg;

  // Field widths of the stream beats and the configuration word
  localparam int CNT_W   = 64;
  localparam int PCT_W   = 7;
  localparam int CFG_W   = 5;
  // Width wide enough to compare any history length against any depth (up to 511)
  localparam int WLEN_W  = 9;

  localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;

  // One history entry: load in the low half, total in the high half
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] load;
  } hist_entry_t;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_CALC = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } seq_state_t;

endpackage

// ===== rtl/core/wlp_hist_mem.sv =====
// History ring memory: one write port, one registered read port, per-entry valid bits.
module wlp_hist_mem
  import wlp_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output hist_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  hist_entry_t       wr_data
);

  hist_entry_t            mem [DEPTH];
  hist_entry_t            rd_data_r;
  logic                   rd_valid_r;
  logic [DEPTH-1:0]       valid_r;

  // Write the entry and read the addressed one, data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Track which entries have been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry never written reads as zero
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== rtl/core/wlp_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module wlp_div #(
  parameter int W = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  output logic          busy,
  output logic [W-1:0]  quot,
  output logic [W-1:0]  rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   rem_r;
  logic [W-1:0]   quo_r;
  logic [W-1:0]   den_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic [W:0]     shifted;
  logic [W:0]     diff;

  // Trial subtract of the divisor from the partial remainder
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};

  // Step counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/windowed_load_percentage_unit.sv =====
// Top level of the windowed load percentage unit: sequencer, history ring and dividers.
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/in_tready  in_tdata: load [63:0], total [127:64]
//  out_     master     out_tvalid/tready    out_tdata: percentage [6:0]; out_tuser: skipped
//  cfg_     slave      cfg_valid/cfg_ready  cfg_data: history_len [4:0]
//
// A stored sample runs from acceptance through the memory read (ST_READ), forming the
// differences and starting the dividers (ST_CALC), the divider steps until both finish
// (ST_DIV), delivery (ST_DONE) and back to idle. A skipped sample goes from the read
// straight to delivery. The next item is taken while the result waits in the output
// register; only a result still unclaimed at completion stalls.
// Reset (rst_n low, synchronous) clears the valid bits of the history ring at once.
module windowed_load_percentage_unit
  import wlp_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [127:0]      in_tdata,   // load [63:0], total [127:64]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // percentage [6:0], zero [7]
  output logic              out_tuser,  // skipped [0]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
  localparam int MOD_W = IDX_W + 1;
  localparam int RST_LEN = (HISTORY_DEPTH < 16) ? HISTORY_DEPTH : 16;

  seq_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  ring_index_r;
  logic [PCT_W-1:0]  current_percent_r;
  logic [CNT_W-1:0]  in_load_r;
  logic [CNT_W-1:0]  in_total_r;
  logic [CNT_W-1:0]  dt_r;
  logic [CNT_W-1:0]  dl100_r;
  logic              skip_r;
  logic              first_r;
  logic              out_valid_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic              out_skip_r;

  hist_entry_t       rd_entry;
  hist_entry_t       wr_entry;
  logic              mem_wr_en;
  logic [CNT_W-1:0]  dt;
  logic [CNT_W-1:0]  dl;
  logic [CNT_W-1:0]  dl100;
  logic              in_fire;
  logic              div_start;
  logic              pct_busy;
  logic [CNT_W-1:0]  pct_quot;
  logic [CNT_W-1:0]  pct_rem;
  logic              idx_busy;
  logic [MOD_W-1:0]  idx_quot;
  logic [MOD_W-1:0]  idx_rem;
  logic [MOD_W-1:0]  idx_succ;
  logic [PCT_W-1:0]  pct_sat;
  logic              deliver;
  logic [WLEN_W-1:0] cfg_wide;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the written history length into 1..HISTORY_DEPTH
  assign cfg_wide = WLEN_W'(cfg_data);
  always_comb begin
    if (cfg_wide == '0) begin
      len_nxt = LEN_W'(1);
    end else if (cfg_wide > WLEN_W'(HISTORY_DEPTH)) begin
      len_nxt = LEN_W'(HISTORY_DEPTH);
    end else begin
      len_nxt = cfg_wide[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(RST_LEN);
    end else if (cfg_valid && cfg_ready) begin
      len_r <= len_nxt;
    end
  end

  // History ring, read at acceptance, written back in the following cycle when the total has moved
  assign wr_entry.load  = in_load_r;
  assign wr_entry.total = in_total_r;
  assign mem_wr_en      = (state_r == ST_READ) && (dt != '0);

  wlp_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .IDX_W (IDX_W)
  ) u_hist_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (ring_index_r),
    .rd_data (rd_entry),
    .wr_en   (mem_wr_en),
    .wr_addr (ring_index_r),
    .wr_data (wr_entry)
  );

  // Differences against the oldest entry; 100 * dl as shift-and-add
  assign dt    = in_total_r - rd_entry.total;
  assign dl    = in_load_r - rd_entry.load;
  assign dl100 = (dl << 6) + (dl << 5) + (dl << 2);

  // Dividers: percentage quotient and ring index modulo the window length
  assign div_start = (state_r == ST_CALC);
  assign idx_succ  = {1'b0, ring_index_r} + MOD_W'(1);

  wlp_div #(.W(CNT_W)) u_pct_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dl100_r),
    .divisor  (dt_r),
    .busy     (pct_busy),
    .quot     (pct_quot),
    .rem      (pct_rem)
  );

  wlp_div #(.W(MOD_W)) u_idx_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (idx_succ),
    .divisor  (MOD_W'(len_r)),
    .busy     (idx_busy),
    .quot     (idx_quot),
    .rem      (idx_rem)
  );

  // Saturate the quotient at full scale; against an entry with zero total the result is zero
  always_comb begin
    if (first_r) begin
      pct_sat = '0;
    end else if ((pct_quot[CNT_W-1:PCT_W] != '0) || (pct_quot[PCT_W-1:0] > FULL_SCALE)) begin
      pct_sat = FULL_SCALE;
    end else begin
      pct_sat = pct_quot[PCT_W-1:0];
    end
  end

  assign deliver = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_READ;
      ST_READ: state_nxt = (dt == '0) ? ST_DONE : ST_CALC;
      ST_CALC: state_nxt = ST_DIV;
      ST_DIV:  if (!pct_busy && !idx_busy) state_nxt = ST_DONE;
      ST_DONE: if (deliver) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the input beat and the differences
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_load_r  <= in_tdata[CNT_W-1:0];
      in_total_r <= in_tdata[2*CNT_W-1:CNT_W];
    end
    if (state_r == ST_READ) begin
      dt_r    <= dt;
      dl100_r <= dl100;
      skip_r  <= (dt == '0);
      first_r <= (rd_entry.total == '0);
    end
  end

  // Advance the ring and the current percentage on delivery of a stored sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_index_r      <= '0;
      current_percent_r <= '0;
    end else if (deliver && !skip_r) begin
      ring_index_r      <= idx_rem[IDX_W-1:0];
      current_percent_r <= pct_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_pct_r  <= skip_r ? current_percent_r : pct_sat;
      out_skip_r <= skip_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pct_r};
  assign out_tuser  = out_skip_r;

endmodule

// ===== test/load_percent_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the windowed load percentage unit: tracks the history ring and checks each result beat.
module load_percent_checker
  import wlp_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [127:0]     in_tdata,   // load [63:0], total [127:64]
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [7:0]       out_tdata,  // percentage [6:0], zero [7]
  input  logic             out_tuser,  // skipped [0]
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [PCT_W-1:0] percentage;
    logic             skipped;
  } load_result_t;

  logic [CNT_W-1:0] load_hist  [HISTORY_DEPTH];
  logic [CNT_W-1:0] total_hist [HISTORY_DEPTH];
  int unsigned      ring_pos;
  int unsigned      window_len;
  logic [PCT_W-1:0] held_pct;
  load_result_t     expected_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Zero is taken as one entry, anything past the ring depth as the full ring
  function automatic int unsigned window_from_code(input logic [CFG_W-1:0] code);
    if (code == '0) return 1;
    if (code > HISTORY_DEPTH) return HISTORY_DEPTH;
    return 32'(code);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t load_percent_checker: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic clear_window();
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      load_hist[i]  = '0;
      total_hist[i] = '0;
    end
    ring_pos   = 0;
    held_pct   = '0;
    window_len = window_from_code(5'd16);
  endtask

  // Compare the sample against the oldest entry and queue the percentage it yields
  task automatic predict_window_percent(input logic [CNT_W-1:0] ld, input logic [CNT_W-1:0] tt);
    int unsigned      slot;
    logic [CNT_W-1:0] span, busy, quot;
    load_result_t     want;
    slot = ring_pos;
    if (slot >= HISTORY_DEPTH) slot = 0;
    span = tt - total_hist[slot];
    if (span == '0) begin
      want.percentage = held_pct;
      want.skipped    = 1'b1;
    end else begin
      busy = ld - load_hist[slot];
      if (total_hist[slot] == '0) begin
        held_pct = '0;
      end else begin
        quot     = (busy * 64'd100) / span;
        held_pct = (quot > FULL_SCALE) ? FULL_SCALE : quot[PCT_W-1:0];
      end
      load_hist[slot]  = ld;
      total_hist[slot] = tt;
      ring_pos         = (slot + 1) % window_len;
      want.percentage  = held_pct;
      want.skipped     = 1'b0;
    end
    expected_q.push_back(want);
  endtask

  task automatic check_result(input logic [7:0] data, input logic flag);
    load_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat: percentage %0d skipped %b",
                                data[PCT_W-1:0], flag));
      return;
    end
    want = expected_q.pop_front();
    if (data[PCT_W-1:0] !== want.percentage)
      report_mismatch($sformatf("percentage %0d, expected %0d", data[PCT_W-1:0],
                                want.percentage));
    if (flag !== want.skipped)
      report_mismatch($sformatf("skipped %b, expected %b", flag, want.skipped));
    if (data[7:PCT_W] !== '0)
      report_mismatch($sformatf("padding bits of result beat are %b", data[7:PCT_W]));
  endtask

  // Retire result beats before queueing new samples taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_window();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) window_len = window_from_code(cfg_data);
      if (out_tvalid && out_tready) check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready)
        predict_window_percent(in_tdata[CNT_W-1:0], in_tdata[2*CNT_W-1:CNT_W]);
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== test/windowed_load_percentage_unit_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the windowed load percentage unit; checking sits in load_percent_checker.
module windowed_load_percentage_unit_tb;
  import wlp_pkg::*;

  localparam int DEPTH        = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 142;
  localparam int HOLD_AT_BEAT = 400;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 100;
  localparam logic [CNT_W-1:0] ALL_ONES = '1;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [127:0]     in_tdata  = '0;   // load [63:0], total [127:64]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;        // percentage [6:0], zero [7]
  logic             out_tuser;        // skipped [0]
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  int               fail_count;
  int               outstanding;
  bit               quiet = 1'b0;

  // Running counters of the well-formed stream and totals the ring should hold
  logic [CNT_W-1:0] run_load  = '0;
  logic [CNT_W-1:0] run_total = '0;
  logic [CNT_W-1:0] recent_totals[$];
  int unsigned      active_len = DEPTH;

  always #2 clk = ~clk;

  windowed_load_percentage_unit #(
    .HISTORY_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  load_percent_checker #(
    .HISTORY_DEPTH(DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Offer one sample beat; valid drops only when a gap is drawn
  task automatic send_sample(input logic [CNT_W-1:0] ld, input logic [CNT_W-1:0] tt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tt, ld};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_window_len(input logic [CFG_W-1:0] code);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    active_len = (code == '0) ? 1 : ((code > DEPTH) ? DEPTH : code);
  endtask

  // Stop offering and wait until every result beat has been claimed
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic note_stored_total(input logic [CNT_W-1:0] tt);
    recent_totals.push_back(tt);
    if (recent_totals.size() > DEPTH) void'(recent_totals.pop_front());
  endtask

  task automatic send_random_sample();
    logic [CNT_W-1:0] step, lift;
    int               kind, share;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // advance both counters, load by a random share of the elapsed ticks
      case ($urandom_range(0, 3))
        0:       step = $urandom_range(1, 1000);
        1:       step = {32'd0, $urandom};
        2:       step = {$urandom, $urandom} >> $urandom_range(1, 40);
        default: step = {$urandom, $urandom};
      endcase
      share     = $urandom_range(0, 110);
      lift      = (step / 100) * share + ((step % 100) * share) / 100;
      run_total = run_total + step;
      run_load  = run_load + lift;
      note_stored_total(run_total);
      send_sample(run_load, run_total);
    end else if (kind < 82 && recent_totals.size() >= active_len) begin
      // repeat the total held by the oldest entry: no ticks elapsed
      send_sample({$urandom, $urandom}, recent_totals[recent_totals.size() - active_len]);
    end else if (kind < 93) begin
      run_load  = {$urandom, $urandom};
      run_total = {$urandom, $urandom};
      note_stored_total(run_total);
      send_sample(run_load, run_total);
    end else begin
      // park both counters just short of wrapping
      run_load  = ALL_ONES - $urandom_range(0, 50);
      run_total = ALL_ONES - $urandom_range(0, 50);
      note_stored_total(run_total);
      send_sample(run_load, run_total);
    end
  endtask

  // Result side: random stalls, plus one long hold-off that backs the block up
  initial begin : result_sink
    int gap;
    int beats;
    bit held;
    beats = 0;
    held  = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (!held && beats == HOLD_AT_BEAT) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      beats++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] codes [PHASES];
    int p, k;
    codes = '{5'd31, 5'd1, 5'd17, 5'd2, 5'd16, 5'd5, 5'd0, 5'd0};
    codes[6] = CFG_W'($urandom_range(3, 31));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window of sixteen: nothing elapsed against a cleared entry, then first passes
    send_sample('0, '0);
    send_sample(ALL_ONES, ALL_ONES);
    send_sample('0, 64'd1);
    send_sample(64'd1, 64'd2);
    drain_pipeline();

    // Zero length is taken as one; the index sits above it, so the ring folds back
    write_window_len(5'd0);
    send_sample(64'd100, 64'd1000);
    send_sample(64'd600, 64'd2000);
    send_sample(64'd600, 64'd2000);                 // no ticks: skipped
    send_sample(64'd1600, 64'd3000);                // fully busy
    send_sample(64'd1600, 64'd4000);                // idle
    send_sample(64'd5000, 64'd4001);                // more work than ticks: saturate
    send_sample(64'd5000 + (64'd1 << 62), 64'd4001 + (64'd1 << 40)); // scaled delta wraps
    send_sample(64'd7, 64'd5);                      // total wraps round
    send_sample(64'd3, 64'd900);                    // load runs backwards
    send_sample(ALL_ONES, ALL_ONES);
    send_sample('0, '0);                            // both wrap by one
    send_sample('0, '0);                            // no ticks: skipped
    drain_pipeline();

    // Random phases, each under its own window length; every third runs without gaps
    for (p = 0; p < PHASES; p++) begin
      quiet = (p % 3 == 2);
      write_window_len(codes[p]);
      for (k = 0; k < PHASE_ITEMS; k++) send_random_sample();
      drain_pipeline();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("windowed_load_percentage_unit_tb: PASS");
    end else begin
      $display("windowed_load_percentage_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("windowed_load_percentage_unit_tb: FAIL");
    $finish;
  end

endmodule
